// File: rtl/core/swbm_pkg.sv
`timescale 1ns / 1ps

package swbm_pkg;

    localparam int TIMER_BITS = 10;
    localparam int CNT_MAX    = (1 << TIMER_BITS) - 1;

    localparam int CFG_W      = 10;
    localparam int CFG_COUNT  = 7;
    localparam int CFG_IDX_W  = 3;

    typedef logic [TIMER_BITS-1:0] ticks_t;
    typedef logic [CFG_W-1:0]      cfg_word_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

    // register indexes on the configuration port
    localparam cfg_idx_t CFG_RESET_LOW     = 3'd0;
    localparam cfg_idx_t CFG_PRESENCE_WAIT = 3'd1;
    localparam cfg_idx_t CFG_RESET_TAIL    = 3'd2;
    localparam cfg_idx_t CFG_SHORT_LOW     = 3'd3;
    localparam cfg_idx_t CFG_LONG_LOW      = 3'd4;
    localparam cfg_idx_t CFG_READ_SAMPLE   = 3'd5;
    localparam cfg_idx_t CFG_SLOT_TOTAL    = 3'd6;

    localparam cfg_word_t CFG_RESET_VAL [CFG_COUNT] = '{
        10'd480, 10'd70, 10'd410, 10'd6, 10'd60, 10'd9, 10'd70
    };

    typedef enum logic [2:0] {
        K_TICK  = 3'd0,
        K_RESET = 3'd1,
        K_WBIT  = 3'd2,
        K_RBIT  = 3'd3,
        K_WBYTE = 3'd4,
        K_RBYTE = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RST_LOW  = 3'd1,
        PH_RST_WAIT = 3'd2,
        PH_RST_TAIL = 3'd3,
        PH_SLOT     = 3'd4
    } phase_t;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // zero counts as one tick, large values clamp to the counter range
    function automatic ticks_t eff_ticks(input cfg_word_t v);
        ticks_t r;
        if (v == '0)
            r = ticks_t'(1);
        else if (32'(v) > CNT_MAX)
            r = ticks_t'(CNT_MAX);
        else
            r = ticks_t'(v);
        return r;
    endfunction

endpackage

// File: rtl/core/single_wire_bus_master.sv
`timescale 1ns / 1ps
// channel   direction  word                     fields (lsb first)
// s_axis    in         command or 1 us tick     tuser: kind; tdata: tx_data, line_level
// m_axis    out        one status word per in   tdata: drive_low, busy_res, done_res,
//                                                      presence, rx_data, rejected
// cfg       in         timing register write    cfg_index, cfg_data
//
// One input word per cycle while s_axis_tready is high; its status word is registered.
// Bus state updates in a single combinational pass between the state registers
// and the output register.
// rst_n clears bus state and loads the default timings.
// s_axis_tready drops only while a status word is held and m_axis_tready is low.

module single_wire_bus_master
    import swbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // tx_data[7:0], line_level[8], zero fill
    input  logic [2:0]            s_axis_tuser,  // kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // drive_low, busy_res, done_res, presence,
                                                 // rx_data[11:4], rejected[12], zero fill
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    ticks_t     cfg_reg [CFG_COUNT];

    phase_t     phase_reg, phase_next;
    ticks_t     tcnt_reg, tcnt_next;
    logic [2:0] bit_reg, bit_next;
    logic [7:0] tx_reg, tx_next;
    logic [7:0] rx_reg, rx_next;
    kind_t      op_reg, op_next;
    logic       pres_reg, pres_next;
    logic       done_next, rej_next;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                  accept;
    kind_t                 kind;
    logic [7:0]            tx_data;
    logic                  line_level;

    ticks_t                tick_inc;
    ticks_t                low_cur, low_nxt;
    logic [TIMER_BITS:0]   at_sum, at_pt;
    logic                  is_read_cur, is_read_nxt, drive_low;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign kind          = kind_t'(s_axis_tuser);
    assign tx_data       = s_axis_tdata[7:0];
    assign line_level    = s_axis_tdata[8];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_COUNT; i++)
                cfg_reg[i] <= eff_ticks(CFG_RESET_VAL[i]);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RESET_LOW:     cfg_reg[0] <= eff_ticks(cfg_data);
                CFG_PRESENCE_WAIT: cfg_reg[1] <= eff_ticks(cfg_data);
                CFG_RESET_TAIL:    cfg_reg[2] <= eff_ticks(cfg_data);
                CFG_SHORT_LOW:     cfg_reg[3] <= eff_ticks(cfg_data);
                CFG_LONG_LOW:      cfg_reg[4] <= eff_ticks(cfg_data);
                CFG_READ_SAMPLE:   cfg_reg[5] <= eff_ticks(cfg_data);
                CFG_SLOT_TOTAL:    cfg_reg[6] <= eff_ticks(cfg_data);
                default: ;
            endcase
        end
    end

    assign is_read_cur = (op_reg == K_RBIT) || (op_reg == K_RBYTE);
    assign low_cur     = (is_read_cur || tx_reg[0]) ? cfg_reg[3] : cfg_reg[4];
    assign at_sum      = {1'b0, low_cur} + {1'b0, cfg_reg[5]};
    assign at_pt       = (at_sum > {1'b0, cfg_reg[6]}) ? {1'b0, cfg_reg[6]} : at_sum;
    assign tick_inc    = tcnt_reg + ticks_t'(1);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        tcnt_next  = tcnt_reg;
        bit_next   = bit_reg;
        tx_next    = tx_reg;
        rx_next    = rx_reg;
        op_next    = op_reg;
        pres_next  = pres_reg;
        done_next  = 1'b0;
        rej_next   = 1'b0;
        case (kind)
            K_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    tcnt_next = tick_inc;
                    case (phase_reg)
                        PH_RST_LOW:
                        begin
                            if (tick_inc >= cfg_reg[0])
                            begin
                                phase_next = PH_RST_WAIT;
                                tcnt_next  = '0;
                            end
                        end
                        PH_RST_WAIT:
                        begin
                            if (tick_inc >= cfg_reg[1])
                            begin
                                pres_next  = !line_level;
                                phase_next = PH_RST_TAIL;
                                tcnt_next  = '0;
                            end
                        end
                        PH_RST_TAIL:
                        begin
                            if (tick_inc >= cfg_reg[2])
                            begin
                                phase_next = PH_IDLE;
                                tcnt_next  = '0;
                                done_next  = 1'b1;
                            end
                        end
                        PH_SLOT:
                        begin
                            if (is_read_cur && ({1'b0, tick_inc} == at_pt) && line_level)
                                rx_next[bit_reg] = 1'b1;
                            if (tick_inc >= cfg_reg[6])
                            begin
                                tcnt_next = '0;
                                if ((op_reg == K_WBYTE || op_reg == K_RBYTE) && bit_reg != 3'd7)
                                begin
                                    bit_next = bit_reg + 3'd1;
                                    tx_next  = {1'b0, tx_reg[7:1]};
                                end
                                else
                                begin
                                    phase_next = PH_IDLE;
                                    done_next  = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            K_RESET, K_WBIT, K_RBIT, K_WBYTE, K_RBYTE:
            begin
                if (phase_reg != PH_IDLE)
                    rej_next = 1'b1;
                else
                begin
                    op_next   = kind;
                    tcnt_next = '0;
                    bit_next  = '0;
                    if (kind == K_RESET)
                        phase_next = PH_RST_LOW;
                    else
                    begin
                        phase_next = PH_SLOT;
                        tx_next    = (kind == K_WBIT) ? {7'd0, tx_data[0]} : tx_data;
                        if (kind == K_RBIT || kind == K_RBYTE)
                            rx_next = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    // status word
    assign is_read_nxt = (op_next == K_RBIT) || (op_next == K_RBYTE);
    assign low_nxt     = (is_read_nxt || tx_next[0]) ? cfg_reg[3] : cfg_reg[4];

    always_comb
    begin
        case (phase_next)
            PH_RST_LOW: drive_low = 1'b1;
            PH_SLOT:    drive_low = tcnt_next < low_nxt;
            default:    drive_low = 1'b0;
        endcase
        out_data_next = '0;
        out_data_next[0]    = drive_low;
        out_data_next[1]    = phase_next != PH_IDLE;
        out_data_next[2]    = done_next;
        out_data_next[3]    = pres_next;
        out_data_next[11:4] = rx_next;
        out_data_next[12]   = rej_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tcnt_reg      <= '0;
            bit_reg       <= '0;
            tx_reg        <= '0;
            rx_reg        <= '0;
            op_reg        <= K_TICK;
            pres_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                tcnt_reg      <= tcnt_next;
                bit_reg       <= bit_next;
                tx_reg        <= tx_next;
                rx_reg        <= rx_next;
                op_reg        <= op_next;
                pres_reg      <= pres_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

endmodule

// File: rtl/core/swbm_checker.sv
`timescale 1ns / 1ps

module swbm_checker
    import swbm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // word held until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("status word dropped before taken");

    // finishing word leaves the bus idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[1])
        else $error("done with busy set");

    // rejection only happens while an operation runs, and never finishes one
    a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[1] && !m_axis_tdata[2])
        else $error("reject outside busy");

    // line is only pulled low during an operation
    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
        else $error("drive low while idle");

endmodule

bind single_wire_bus_master swbm_checker u_swbm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import swbm_pkg::*;

    typedef logic [2:0] kind_code_t;

    localparam kind_code_t KIND_SPARE_LO = 3'd6;
    localparam kind_code_t KIND_SPARE_HI = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_PRINTS  = 50;

    typedef struct packed {
        kind_code_t  kind;
        logic [7:0]  data;
        logic        level;
    } bus_word_t;

    // same bit order as m_axis_tdata[12:0]
    typedef struct packed {
        logic        rejected;
        logic [7:0]  rx_data;
        logic        presence;
        logic        done_op;
        logic        busy;
        logic        drive_low;
    } bus_status_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // tx_data[7:0], line_level[8], zero fill
    logic [2:0]            s_axis_tuser = '0;  // kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;      // drive_low, busy_res, done_res, presence,
                                              // rx_data[11:4], rejected[12], zero fill
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    single_wire_bus_master uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    bus_word_t   word_q [$];
    bus_status_t status_due [$];
    bus_word_t   next_word;

    cfg_word_t   timing [CFG_COUNT];
    cfg_word_t   next_timing [CFG_COUNT];

    // bus master state as predicted
    phase_t      bus_phase = PH_IDLE;
    ticks_t      tick_cnt = '0;
    logic [2:0]  bit_pos = '0;
    logic [7:0]  tx_bits = '0;
    logic [7:0]  rx_bits = '0;
    kind_code_t  op = '0;
    logic        presence_flag = 1'b0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int pushed = 0;
    int words_in = 0;
    int words_out = 0;
    int rejects_seen = 0;
    int presence_hits = 0;
    int settings = 1;
    int stall_cycles = 0;

    function automatic int ticks_of(input cfg_word_t v);
        if (v == '0)
            return 1;
        if (int'(v) > CNT_MAX)
            return CNT_MAX;
        return int'(v);
    endfunction

    function automatic logic reading();
        return op == K_RBIT || op == K_RBYTE;
    endfunction

    function automatic int slot_low_ticks();
        if (reading() || tx_bits[0])
            return ticks_of(timing[CFG_SHORT_LOW]);
        return ticks_of(timing[CFG_LONG_LOW]);
    endfunction

    function automatic bus_status_t bus_step(input kind_code_t kind, input logic [7:0] data,
                                             input logic level);
        bus_status_t s;
        int total;
        int at;
        logic rej;
        logic fin;
        rej = 1'b0;
        fin = 1'b0;
        if (kind == K_TICK)
        begin
            if (bus_phase != PH_IDLE)
            begin
                tick_cnt = tick_cnt + 1'b1;
                case (bus_phase)
                    PH_RST_LOW:
                        if (int'(tick_cnt) >= ticks_of(timing[CFG_RESET_LOW]))
                        begin
                            bus_phase = PH_RST_WAIT;
                            tick_cnt = '0;
                        end
                    PH_RST_WAIT:
                        if (int'(tick_cnt) >= ticks_of(timing[CFG_PRESENCE_WAIT]))
                        begin
                            presence_flag = ~level;
                            bus_phase = PH_RST_TAIL;
                            tick_cnt = '0;
                        end
                    PH_RST_TAIL:
                        if (int'(tick_cnt) >= ticks_of(timing[CFG_RESET_TAIL]))
                        begin
                            bus_phase = PH_IDLE;
                            tick_cnt = '0;
                            fin = 1'b1;
                        end
                    default:
                    begin
                        total = ticks_of(timing[CFG_SLOT_TOTAL]);
                        if (reading())
                        begin
                            at = slot_low_ticks() + ticks_of(timing[CFG_READ_SAMPLE]);
                            if (at > total)
                                at = total;
                            if (int'(tick_cnt) == at && level)
                                rx_bits[bit_pos] = 1'b1;
                        end
                        if (int'(tick_cnt) >= total)
                        begin
                            tick_cnt = '0;
                            if ((op == K_WBYTE || op == K_RBYTE) && bit_pos < 3'd7)
                            begin
                                bit_pos = bit_pos + 1'b1;
                                tx_bits = tx_bits >> 1;
                            end
                            else
                            begin
                                bus_phase = PH_IDLE;
                                fin = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end
        else if (kind <= K_RBYTE)
        begin
            if (bus_phase != PH_IDLE)
            begin
                rej = 1'b1;
            end
            else
            begin
                op = kind;
                tick_cnt = '0;
                bit_pos = '0;
                if (kind == K_RESET)
                begin
                    bus_phase = PH_RST_LOW;
                end
                else
                begin
                    bus_phase = PH_SLOT;
                    tx_bits = (kind == K_WBIT) ? {7'b0, data[0]} : data;
                    if (kind == K_RBIT || kind == K_RBYTE)
                        rx_bits = '0;
                end
            end
        end
        case (bus_phase)
            PH_RST_LOW: s.drive_low = 1'b1;
            PH_SLOT:    s.drive_low = int'(tick_cnt) < slot_low_ticks();
            default:    s.drive_low = 1'b0;
        endcase
        s.busy = bus_phase != PH_IDLE;
        s.done_op = fin;
        s.presence = presence_flag;
        s.rx_data = rx_bits;
        s.rejected = rej;
        return s;
    endfunction

    task automatic report(input string what, input int want, input int got);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
    endtask

    task automatic check_status(input logic [OUT_DATA_W-1:0] word);
        bus_status_t want;
        bus_status_t got;
        got = bus_status_t'(word[12:0]);
        words_out++;
        if (status_due.size() == 0)
        begin
            report("unexpected status word", 0, int'(word));
        end
        else
        begin
            want = status_due.pop_front();
            if (got.drive_low != want.drive_low) report("drive_low", want.drive_low, got.drive_low);
            if (got.busy != want.busy)           report("busy_res", want.busy, got.busy);
            if (got.done_op != want.done_op)     report("done_res", want.done_op, got.done_op);
            if (got.presence != want.presence)   report("presence", want.presence, got.presence);
            if (got.rx_data != want.rx_data)     report("rx_data", want.rx_data, got.rx_data);
            if (got.rejected != want.rejected)   report("rejected", want.rejected, got.rejected);
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_word = word_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {7'b0, next_word.level, next_word.data};
                s_axis_tuser <= next_word.kind;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_status(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
            begin
                status_due.push_back(bus_step(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8]));
                words_in++;
                if (status_due[$].rejected)
                    rejects_seen++;
                if (status_due[$].presence)
                    presence_hits++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    task automatic push_word(input kind_code_t kind, input logic [7:0] data, input logic level);
        word_q.push_back('{kind: kind, data: data, level: level});
        pushed++;
    endtask

    function automatic int ticks_needed(input kind_code_t kind);
        case (kind)
            K_RESET: return ticks_of(timing[CFG_RESET_LOW]) + ticks_of(timing[CFG_PRESENCE_WAIT])
                            + ticks_of(timing[CFG_RESET_TAIL]);
            K_WBYTE, K_RBYTE: return 8 * ticks_of(timing[CFG_SLOT_TOTAL]);
            default: return ticks_of(timing[CFG_SLOT_TOTAL]);
        endcase
    endfunction

    // command, enough ticks to finish it with busy-time noise, then a short idle tail
    task automatic add_op(input kind_code_t kind, input logic [7:0] data, input int noise_pct);
        int n;
        push_word(kind, data, 1'($urandom_range(1)));
        n = ticks_needed(kind);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < noise_pct)
                push_word(kind_code_t'($urandom_range(1, 7)), 8'($urandom), 1'($urandom_range(1)));
            push_word(K_TICK, 8'($urandom), 1'($urandom_range(1)));
        end
        repeat ($urandom_range(2))
            push_word($urandom_range(3) == 0 ? kind_code_t'($urandom_range(6, 7)) : K_TICK,
                      8'($urandom), 1'($urandom_range(1)));
    endtask

    task automatic random_ops(input int target, input int noise_pct);
        int start;
        start = pushed;
        while (pushed - start < target)
            add_op(kind_code_t'($urandom_range(int'(K_RESET), int'(K_RBYTE))), 8'($urandom),
                   noise_pct);
    endtask

    task automatic drain();
        while (word_q.size() != 0 || s_axis_tvalid || status_due.size() != 0)
            @(negedge clk);
        repeat (2) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apply_timings();
        for (int i = 0; i < CFG_COUNT; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data <= next_timing[i];
            timing[i] = next_timing[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        settings++;
    endtask

    initial
    begin
        for (int i = 0; i < CFG_COUNT; i++)
            timing[i] = CFG_RESET_VAL[i];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default timings: idle ticks, spare kinds, commands while busy, bit slots
        push_word(K_TICK, 8'h00, 1'b0);
        push_word(K_TICK, 8'hFF, 1'b1);
        push_word(KIND_SPARE_LO, 8'h00, 1'b0);
        push_word(KIND_SPARE_HI, 8'hFF, 1'b1);
        push_word(K_WBIT, 8'hFF, 1'b1);
        for (int k = int'(K_RESET); k <= int'(K_RBYTE); k++)
            push_word(kind_code_t'(k), 8'hFF, 1'b0);
        push_word(KIND_SPARE_HI, 8'h5A, 1'b0);
        for (int i = 0; i < ticks_needed(K_WBIT); i++)
            push_word(K_TICK, 8'($urandom), 1'($urandom_range(1)));
        add_op(K_RBIT, 8'h00, 0);
        add_op(K_WBIT, 8'h00, 0);
        drain();

        // short random timings under each idling mix
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = (p == 1) ? 67 : (p == 3) ? 29 : 0;
            recv_stall_pct = (p == 2) ? 67 : (p == 3) ? 29 : 0;
            for (int i = 0; i < CFG_COUNT; i++)
                next_timing[i] = cfg_word_t'($urandom_range(12));
            next_timing[CFG_SLOT_TOTAL] = cfg_word_t'($urandom_range(2, 12));
            apply_timings();
            random_ops(40, 3);
            drain();
        end

        // all registers zero
        send_idle_pct = 29;
        recv_stall_pct = 29;
        for (int i = 0; i < CFG_COUNT; i++)
            next_timing[i] = '0;
        apply_timings();
        random_ops(30, 5);
        drain();

        // two-tick slot, low times at or past the slot end, read sample past the slot end
        send_idle_pct = 29;
        recv_stall_pct = 29;
        next_timing[CFG_RESET_LOW] = 10'd1;
        next_timing[CFG_PRESENCE_WAIT] = 10'd1;
        next_timing[CFG_RESET_TAIL] = 10'd1;
        next_timing[CFG_SHORT_LOW] = 10'd1023;
        next_timing[CFG_LONG_LOW] = 10'd2;
        next_timing[CFG_READ_SAMPLE] = 10'd1023;
        next_timing[CFG_SLOT_TOTAL] = 10'd2;
        apply_timings();
        random_ops(30, 5);
        drain();

        repeat (4) @(posedge clk);
        if (status_due.size() != 0)
            report("status words missing", 0, status_due.size());
        $display("%0d words sent, %0d status words checked, %0d busy commands rejected",
                 words_in, words_out, rejects_seen);
        $display("%0d timing settings from defaults through all-zero and one-tick slots, %0d %s",
                 settings, presence_hits, "words with presence set");
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
